// ----- hdl/npor_pkg.sv -----
`timescale 1ns / 1ps

package npor_pkg;

	// Table size and field widths of the transfer payloads
	localparam int MAX_POINTS = 16;
	localparam int COORD_BITS = 8;
	localparam int LEVEL_BITS = 12;
	localparam int SLOT_BITS  = 4;
	localparam int COUNT_BITS = 5;
	localparam int DIST_BITS  = 2 * COORD_BITS + 1;

	// APB register map
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam logic [0:0] REG_POINT_COUNT = 1'b0;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ROUTE = 1'b1
	} op_e;

	typedef struct packed {
		logic                  operation;
		logic [SLOT_BITS-1:0]  slot_index;
		logic [COORD_BITS-1:0] coord_x;
		logic [COORD_BITS-1:0] coord_y;
		logic [LEVEL_BITS-1:0] drive_level;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_BITS-1:0]  chosen_slot;
		logic [LEVEL_BITS-1:0] out_level;
		logic                  no_point;
	} out_item_t;

	// Search token handed from cell to cell
	typedef struct packed {
		logic [COORD_BITS-1:0] tgt_x;
		logic [COORD_BITS-1:0] tgt_y;
		logic [LEVEL_BITS-1:0] level;
		logic                  has_best;
		logic [DIST_BITS-1:0]  best_dist;
		logic [SLOT_BITS-1:0]  best_slot;
	} scan_tok_t;

endpackage

// ----- hdl/npor_cell.sv -----
`timescale 1ns / 1ps

module npor_cell
	import npor_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  load_en,
	input  logic [COORD_BITS-1:0] load_x,
	input  logic [COORD_BITS-1:0] load_y,
	input  logic                  active,
	input  logic [SLOT_BITS-1:0]  slot_id,
	input  logic                  tok_in_valid,
	input  scan_tok_t             tok_in,
	output logic                  tok_out_valid,
	output scan_tok_t             tok_out
);

	logic [COORD_BITS-1:0]   px_q;
	logic [COORD_BITS-1:0]   py_q;
	logic                    tok_valid_q;
	scan_tok_t               tok_q;
	logic [COORD_BITS-1:0]   dx;
	logic [COORD_BITS-1:0]   dy;
	logic [2*COORD_BITS-1:0] sq_x;
	logic [2*COORD_BITS-1:0] sq_y;
	logic [DIST_BITS-1:0]    dist_sq;
	logic                    take;
	scan_tok_t               tok_nxt;

	// Hold this cell's point
	always_ff @(posedge clk) begin
		if (load_en) begin
			px_q <= load_x;
			py_q <= load_y;
		end
	end

	// Squared distance from the passing target to this point
	always_comb begin
		dx      = (tok_in.tgt_x >= px_q) ? (tok_in.tgt_x - px_q) : (px_q - tok_in.tgt_x);
		dy      = (tok_in.tgt_y >= py_q) ? (tok_in.tgt_y - py_q) : (py_q - tok_in.tgt_y);
		sq_x    = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
		sq_y    = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
		dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
	end

	// Replace the best so far only on a strictly smaller distance
	always_comb begin
		take    = active && (!tok_in.has_best || (dist_sq < tok_in.best_dist));
		tok_nxt = tok_in;
		if (take) begin
			tok_nxt.has_best  = 1'b1;
			tok_nxt.best_dist = dist_sq;
			tok_nxt.best_slot = slot_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (advance) begin
			tok_valid_q <= tok_in_valid;
		end
	end

	// Pass the token on to the next cell
	always_ff @(posedge clk) begin
		if (advance && tok_in_valid) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out_valid = tok_valid_q;
	assign tok_out       = tok_q;

endmodule

// ----- hdl/nearest_point_output_router.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_ready        in_data    (in_item_t)
// out       output     out_valid / out_ready      out_data   (out_item_t)
// config    input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A load item writes the point of one cell directly and does not make the block busy.
// A route item walks the chain of MAX_POINTS cells, one cell per cycle while the
// chain is not frozen, and its result is then captured in the output register.
// The next item is taken once the result has left the chain, so a route item
// keeps the block busy for its whole walk through the chain.
// Reset clears control state and point_count; points are undefined until loaded.
// A result that waits on out_ready freezes the chain once the next token reaches the tail.

module nearest_point_output_router
	import npor_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	logic [COUNT_BITS-1:0] point_count_q;
	logic                  busy_q;
	logic                  out_valid_q;
	out_item_t             out_q;
	logic                  in_xfer;
	logic                  load_xfer;
	logic                  route_xfer;
	logic                  advance;
	logic                  tail_move;
	logic [MAX_POINTS:0]   chain_v;
	scan_tok_t             chain_tok [MAX_POINTS+1];
	logic [MAX_POINTS-1:0] load_en;
	logic [MAX_POINTS-1:0] active;

	// Register port
	assign pready = 1'b1;
	assign prdata = {{(PDATA_BITS-COUNT_BITS){1'b0}}, point_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == REG_POINT_COUNT)) begin
			point_count_q <= pwdata[COUNT_BITS-1:0];
		end
	end

	// Input transfer decode
	assign in_ready   = !busy_q;
	assign in_xfer    = in_valid && in_ready;
	assign load_xfer  = in_xfer && (in_data.operation == OP_LOAD);
	assign route_xfer = in_xfer && (in_data.operation == OP_ROUTE);

	// Freeze the chain while a finished token cannot leave the tail
	assign advance   = !(chain_v[MAX_POINTS] && out_valid_q && !out_ready);
	assign tail_move = chain_v[MAX_POINTS] && advance;

	// Inject a fresh token at the head
	assign chain_v[0]   = route_xfer;
	assign chain_tok[0] = '{
		tgt_x:     in_data.coord_x,
		tgt_y:     in_data.coord_y,
		level:     in_data.drive_level,
		has_best:  1'b0,
		best_dist: '0,
		best_slot: '0
	};

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		assign load_en[i] = load_xfer && (32'(in_data.slot_index) == i);
		assign active[i]  = 32'(point_count_q) > i;

		npor_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.advance       (advance),
			.load_en       (load_en[i]),
			.load_x        (in_data.coord_x),
			.load_y        (in_data.coord_y),
			.active        (active[i]),
			.slot_id       (SLOT_BITS'(i)),
			.tok_in_valid  (chain_v[i]),
			.tok_in        (chain_tok[i]),
			.tok_out_valid (chain_v[i+1]),
			.tok_out       (chain_tok[i+1])
		);
	end

	// Track a route item from transfer until its result leaves the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (route_xfer) begin
			busy_q <= 1'b1;
		end else if (tail_move) begin
			busy_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tail_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_move) begin
			out_q.no_point    <= !chain_tok[MAX_POINTS].has_best;
			out_q.chosen_slot <= chain_tok[MAX_POINTS].has_best
				? chain_tok[MAX_POINTS].best_slot : '0;
			out_q.out_level   <= chain_tok[MAX_POINTS].has_best
				? chain_tok[MAX_POINTS].level : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// At most one token in the chain
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(chain_v[MAX_POINTS:1]) <= 1)
		else $error("more than one token in the cell chain");

	// An idle block has an empty chain
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (chain_v[MAX_POINTS:1] == '0))
		else $error("token in the chain while the block is idle");

	// A stalled tail token stays put
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_v[MAX_POINTS] && !advance) |=> chain_v[MAX_POINTS])
		else $error("tail token lost during a stall");

	// A result without a point carries zero fields
	a_no_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.no_point) |->
			((out_q.chosen_slot == '0) && (out_q.out_level == '0)))
		else $error("no_point result with nonzero fields");

endmodule

// ----- verif/nearest_point_output_router_test.sv -----
`timescale 1ns / 1ps

module nearest_point_output_router_test;
	import npor_pkg::*;

	localparam int NUM_SLOTS   = MAX_POINTS;
	// a route transfer walks every slot plus the output stage
	localparam int SETTLE_WAIT = NUM_SLOTS + 8;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [PADDR_BITS-1:0] paddr     = '0;
	logic [PDATA_BITS-1:0] pwdata    = '0;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	// predictor state
	logic [COORD_BITS-1:0] point_x [NUM_SLOTS];
	logic [COORD_BITS-1:0] point_y [NUM_SLOTS];
	logic [LEVEL_BITS-1:0] slot_level [NUM_SLOTS];
	logic [COUNT_BITS-1:0] active_points = '0;

	// stimulus-side copy of the loaded points, used to aim route targets
	logic [COORD_BITS-1:0] plan_x [NUM_SLOTS];
	logic [COORD_BITS-1:0] plan_y [NUM_SLOTS];
	int                    plan_count = 0;

	in_item_t  pending_items [$];
	out_item_t routed_results [$];
	int        mismatches     = 0;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;

	nearest_point_output_router u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one accepted transfer to the predictor; route transfers queue a result
	task automatic predict_transfer(input in_item_t item);
		logic [COORD_BITS-1:0] dx;
		logic [COORD_BITS-1:0] dy;
		logic [DIST_BITS-1:0]  sq_dist;
		logic [DIST_BITS-1:0]  best_sq;
		logic [SLOT_BITS-1:0]  best_slot;
		out_item_t             res;
		int                    used;
		used = (active_points > NUM_SLOTS) ? NUM_SLOTS : int'(active_points);
		best_sq = '0;
		best_slot = '0;
		res = '0;
		if (item.operation == OP_LOAD) begin
			point_x[item.slot_index] = item.coord_x;
			point_y[item.slot_index] = item.coord_y;
			return;
		end
		if (used == 0) begin
			res.no_point = 1'b1;
		end else begin
			for (int i = 0; i < used; i++) begin
				dx = (item.coord_x >= point_x[i]) ? item.coord_x - point_x[i]
					: point_x[i] - item.coord_x;
				dy = (item.coord_y >= point_y[i]) ? item.coord_y - point_y[i]
					: point_y[i] - item.coord_y;
				sq_dist = DIST_BITS'(dx) * DIST_BITS'(dx) + DIST_BITS'(dy) * DIST_BITS'(dy);
				if (i == 0 || sq_dist < best_sq) begin
					best_sq = sq_dist;
					best_slot = SLOT_BITS'(i);
				end
			end
			slot_level[best_slot] = item.drive_level;
			res.chosen_slot = best_slot;
			res.out_level = slot_level[best_slot];
		end
		routed_results.insert(routed_results.size(), res);
	endtask

	// Compare one result transfer with the oldest prediction
	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (routed_results.size() == 0) begin
			$error("unexpected result: chosen_slot %0d out_level %0d no_point %0d",
				got.chosen_slot, got.out_level, got.no_point);
			mismatches++;
			return;
		end
		want = routed_results.pop_front();
		if (got.chosen_slot !== want.chosen_slot) begin
			$error("chosen_slot expected %0d actual %0d", want.chosen_slot, got.chosen_slot);
			mismatches++;
		end
		if (got.out_level !== want.out_level) begin
			$error("out_level expected %0d actual %0d", want.out_level, got.out_level);
			mismatches++;
		end
		if (got.no_point !== want.no_point) begin
			$error("no_point expected %0d actual %0d", want.no_point, got.no_point);
			mismatches++;
		end
	endtask

	// Driver: present the next pending item once the current one is transferred
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				predict_transfer(in_data);
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each result transfer, stall the output at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_result(out_data);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic add_item(input op_e op, input int slot, input int x, input int y,
		input int lvl);
		in_item_t item;
		item.operation = op;
		item.slot_index = SLOT_BITS'(slot);
		item.coord_x = COORD_BITS'(x);
		item.coord_y = COORD_BITS'(y);
		item.drive_level = LEVEL_BITS'(lvl);
		if (op == OP_LOAD) begin
			plan_x[slot] = item.coord_x;
			plan_y[slot] = item.coord_y;
		end
		pending_items.insert(pending_items.size(), item);
	endtask

	function automatic int pick_coord();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return $urandom_range(3);
		if (roll < 25)
			return ($urandom_range(1) != 0) ? 255 : 0;
		return $urandom_range(255);
	endfunction

	// Mostly routes, with loads mixed in; targets often land exactly on planned points
	task automatic add_random_item();
		int roll;
		int slot;
		int used;
		int lvl;
		roll = $urandom_range(99);
		used = (plan_count > NUM_SLOTS) ? NUM_SLOTS : plan_count;
		lvl = ($urandom_range(9) == 0) ? (($urandom_range(1) != 0) ? 4095 : 0)
			: $urandom_range(4095);
		if (roll < 30) begin
			slot = $urandom_range(NUM_SLOTS - 1);
			if ($urandom_range(4) == 0) begin
				// duplicate the point of a random slot to make a tie likely
				roll = $urandom_range(NUM_SLOTS - 1);
				add_item(OP_LOAD, slot, plan_x[roll], plan_y[roll], lvl);
			end else begin
				add_item(OP_LOAD, slot, pick_coord(), pick_coord(), lvl);
			end
		end else if (roll < 55 && used > 0) begin
			slot = $urandom_range(used - 1);
			add_item(OP_ROUTE, $urandom_range(15), plan_x[slot], plan_y[slot], lvl);
		end else begin
			add_item(OP_ROUTE, $urandom_range(15), pick_coord(), pick_coord(), lvl);
		end
	endtask

	task automatic write_point_count(input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_BITS'({REG_POINT_COUNT, 2'b00});
		pwdata <= PDATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		active_points = COUNT_BITS'(value);
		plan_count = value;
	endtask

	// Wait until every item is transferred and every result has arrived
	task automatic settle();
		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (routed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	initial begin
		int counts [8];
		for (int i = 0; i < NUM_SLOTS; i++)
			slot_level[i] = '0;
		counts = '{16, 1, 31, 0, 17, 16, 0, 0};
		counts[6] = $urandom_range(2, 15);
		counts[7] = $urandom_range(1, 16);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no points in use: route flags no_point; then fill every slot
		write_point_count(0);
		add_item(OP_ROUTE, 15, 255, 255, 4095);
		add_item(OP_LOAD, 0, 0, 0, 0);
		add_item(OP_LOAD, 1, 255, 255, 4095);
		add_item(OP_LOAD, 2, 10, 10, 0);
		add_item(OP_LOAD, 3, 12, 10, 0);
		add_item(OP_LOAD, 4, 0, 255, 0);
		add_item(OP_LOAD, 5, 200, 50, 0);
		add_item(OP_LOAD, 6, 255, 0, 0);
		add_item(OP_LOAD, 9, 200, 50, 0);
		for (int s = 7; s < NUM_SLOTS; s++)
			if (s != 9)
				add_item(OP_LOAD, s, 40 + 17 * s, 170 - 9 * s, 0);
		settle();

		// all slots in use: extremes, tie between neighbors, exact duplicate
		write_point_count(16);
		add_item(OP_ROUTE, 0, 0, 0, 0);
		add_item(OP_ROUTE, 0, 255, 255, 4095);
		add_item(OP_ROUTE, 0, 11, 10, 2730);
		add_item(OP_ROUTE, 0, 200, 50, 1365);
		add_item(OP_ROUTE, 0, 128, 128, 4095);
		settle();

		// count above the table size acts as a full table
		write_point_count(31);
		add_item(OP_ROUTE, 5, 254, 1, 1);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			write_point_count(counts[ph]);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 77;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 77;
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
				end
			endcase
			for (int n = 0; n < 62; n++)
				add_random_item();
			settle();
		end

		if (mismatches == 0) begin
			$display("nearest_point_output_router: match");
		end else begin
			$display("nearest_point_output_router: mismatch");
		end
		$finish;
	end

	// Hard stop far beyond the slowest correct run
	initial begin
		#400000;
		$display("nearest_point_output_router: mismatch");
		$finish;
	end

endmodule
